// ===== rtl/allpass_first_order_q30_defines.svh =====
// Assertion macros shared by the verification-only files of the all-pass filter.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef ALLPASS_FIRST_ORDER_Q30_DEFINES_SVH
`define ALLPASS_FIRST_ORDER_Q30_DEFINES_SVH

// Check a property outside reset.
`define APFO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("apfo assertion failed");

// Check a property that also covers the reset cycles.
`define APFO_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("apfo reset assertion failed");

`endif

// ===== rtl/apfo_pkg.sv =====
// Shared types and constants of the first-order all-pass filter.
// No dependencies; imported by every module of the block.
package apfo_pkg;

    // Q format of the coefficients
    localparam int FRAC_BITS = 30;

    // Datapath widths
    localparam int SMP_W  = 32;
    localparam int PROD_W = 2 * SMP_W;
    localparam int FF_W   = PROD_W + 1;
    localparam int ACC_W  = FF_W + 1;
    localparam int SCL_W  = ACC_W - FRAC_BITS;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0 = 2'd0,
        CFG_B1 = 2'd1,
        CFG_A1 = 2'd2
    } t_cfg_idx;

    localparam logic signed [SMP_W-1:0] B0_RESET = 32'sh0000_0000;
    localparam logic signed [SMP_W-1:0] B1_RESET = 32'sh4000_0000;
    localparam logic signed [SMP_W-1:0] A1_RESET = 32'sh0000_0000;

    // Clamp limits
    localparam logic [SMP_W-1:0] SAT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] SAT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SMP_W-1:0] b0;
        logic [SMP_W-1:0] b1;
        logic [SMP_W-1:0] a1;
    } t_coefs;

    // One sample after the feedforward part
    typedef struct packed {
        logic            clr;
        logic [FF_W-1:0] ff;
    } t_ff_item;

endpackage

// ===== rtl/apfo_front.sv =====
// Front end: accepts samples, keeps the previous input and forms b0*x + b1*x1.
// Depends on apfo_pkg.
module apfo_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  apfo_pkg::t_coefs          i_coefs,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [apfo_pkg::SMP_W-1:0] i_sample,
    input  logic                      i_clear,
    output logic                      o_push,
    output apfo_pkg::t_ff_item        o_item,
    input  logic                      i_full
);
    import apfo_pkg::*;

    logic                     r_v1;
    logic                     r_v2;
    logic signed [SMP_W-1:0]  r_x1;
    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic                     r_clr1;
    logic [FF_W-1:0]          r_ff;
    logic                     r_clr2;

    logic                     en1;
    logic                     en2;
    logic                     accept;
    logic signed [SMP_W-1:0]  x_cur;
    logic signed [SMP_W-1:0]  x1_eff;
    logic signed [PROD_W-1:0] b0_x;
    logic signed [PROD_W-1:0] b1_x;
    logic signed [PROD_W-1:0] x_x;
    logic signed [PROD_W-1:0] x1_x;

    // Advance each stage when the one after it has room
    assign o_push  = r_v2 && !i_full;
    assign en2     = !r_v2 || o_push;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign accept  = i_valid && en1;

    // Drop the history on a clear beat
    assign x_cur  = $signed(i_sample);
    assign x1_eff = i_clear ? '0 : r_x1;

    // Sign-extend multiplier operands
    assign b0_x = {{(PROD_W-SMP_W){i_coefs.b0[SMP_W-1]}}, i_coefs.b0};
    assign b1_x = {{(PROD_W-SMP_W){i_coefs.b1[SMP_W-1]}}, i_coefs.b1};
    assign x_x  = {{(PROD_W-SMP_W){x_cur[SMP_W-1]}}, x_cur};
    assign x1_x = {{(PROD_W-SMP_W){x1_eff[SMP_W-1]}}, x1_eff};

    // Stage valids and the previous input
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_x1 <= '0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (accept) begin
                r_x1 <= x_cur;
            end
        end
    end

    // Products, then their sum
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p0   <= b0_x * x_x;
            r_p1   <= b1_x * x1_x;
            r_clr1 <= i_clear;
        end
        if (en2 && r_v1) begin
            r_ff   <= {r_p0[PROD_W-1], r_p0} + {r_p1[PROD_W-1], r_p1};
            r_clr2 <= r_clr1;
        end
    end

    assign o_item.clr = r_clr2;
    assign o_item.ff  = r_ff;

endmodule

// ===== rtl/apfo_queue.sv =====
// Small FIFO that decouples the feedforward front from the feedback back end.
// Depends on apfo_pkg.
module apfo_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  apfo_pkg::t_ff_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output apfo_pkg::t_ff_item o_item,
    output logic               o_empty
);
    import apfo_pkg::*;

    t_ff_item             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/apfo_back.sv =====
// Back end: the output feedback loop, error-feedback residual, clamp and output register.
// Depends on apfo_pkg.
module apfo_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [apfo_pkg::SMP_W-1:0] i_a1,
    input  logic                       i_empty,
    input  apfo_pkg::t_ff_item         i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [apfo_pkg::SMP_W-1:0] o_sample,
    output logic                       o_sat
);
    import apfo_pkg::*;

    logic                     r_vb;
    logic signed [SMP_W-1:0]  r_y1;
    logic [FRAC_BITS-1:0]     r_res;
    logic signed [PROD_W-1:0] r_m;
    logic [FF_W-1:0]          r_ffb;
    logic [FRAC_BITS-1:0]     r_resb;
    logic                     r_ov;
    logic [SMP_W-1:0]         r_oy;
    logic                     r_osat;

    logic                     issue;
    logic                     fire;
    logic signed [SMP_W-1:0]  y1_eff;
    logic [FRAC_BITS-1:0]     res_eff;
    logic signed [PROD_W-1:0] a1_x;
    logic signed [PROD_W-1:0] y1_x;
    logic [ACC_W-1:0]         ff_x;
    logic [ACC_W-1:0]         m_x;
    logic [ACC_W-1:0]         res_x;
    logic [ACC_W-1:0]         acc;
    logic [SCL_W-1:0]         scaled;
    logic [SCL_W-SMP_W:0]     top_bits;
    logic                     ovf;
    logic [SMP_W-1:0]         y;

    // Issue only into an empty loop stage, so y1 is always settled
    assign issue = !i_empty && !r_vb;
    assign o_pop = issue;
    assign fire  = r_vb && (!r_ov || i_ready);

    // Drop the history on a clear beat
    assign y1_eff  = i_item.clr ? '0 : r_y1;
    assign res_eff = i_item.clr ? '0 : r_res;

    assign a1_x = {{(PROD_W-SMP_W){i_a1[SMP_W-1]}}, i_a1};
    assign y1_x = {{(PROD_W-SMP_W){y1_eff[SMP_W-1]}}, y1_eff};

    // Exact sum, floor shift and clamp
    assign ff_x     = {{(ACC_W-FF_W){r_ffb[FF_W-1]}}, r_ffb};
    assign m_x      = {{(ACC_W-PROD_W){r_m[PROD_W-1]}}, r_m};
    assign res_x    = {{(ACC_W-FRAC_BITS){1'b0}}, r_resb};
    assign acc      = ff_x - m_x + res_x;
    assign scaled   = acc[ACC_W-1:FRAC_BITS];
    assign top_bits = scaled[SCL_W-1:SMP_W-1];
    assign ovf      = !((&top_bits) || !(|top_bits));
    assign y        = ovf ? (scaled[SCL_W-1] ? SAT_MIN : SAT_MAX) : scaled[SMP_W-1:0];

    // Loop control, history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb  <= 1'b0;
            r_y1  <= '0;
            r_res <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (issue) begin
                r_vb <= 1'b1;
            end else if (fire) begin
                r_vb <= 1'b0;
            end
            if (fire) begin
                r_y1  <= $signed(y);
                r_res <= ovf ? '0 : acc[FRAC_BITS-1:0];
                r_ov  <= 1'b1;
            end else if (i_ready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    // Feedback product and output payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_m    <= a1_x * y1_x;
            r_ffb  <= i_item.ff;
            r_resb <= res_eff;
        end
        if (fire) begin
            r_oy   <= y;
            r_osat <= ovf;
        end
    end

    assign o_valid  = r_ov;
    assign o_sample = r_oy;
    assign o_sat    = r_osat;

endmodule

// ===== rtl/allpass_first_order_q30.sv =====
// First-order all-pass section with error feedback: y = (b0*x + b1*x1 - a1*y1 + r) >> 30,
// clamped to 32 bits. Samples enter on the slave stream, one beat per sample, tuser bit 0
// clears the filter history first. The front end takes a sample every cycle unless a full
// queue backs it up, and forms the feedforward sum in two stages; a four-entry queue feeds
// the back end, whose output feedback loop (a1*y1 multiply, then the wide accumulate and
// clamp) holds one sample at a time and takes the next only once the last has reached the
// output register. Coefficients are written on the config port (index 0 b0, 1 b1, 2 a1);
// the user must write them only while no sample is in flight; the block does not enforce it.
// Other indexes are ignored. Depends on apfo_pkg, apfo_front, apfo_queue and apfo_back.
module allpass_first_order_q30 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: [31:0] sample_in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,
    // tuser: [0] clear_history
    input  logic [0:0]                     s_axis_tuser,
    // tdata: [31:0] sample_out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,
    // tuser: [0] saturated
    output logic [0:0]                     m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [apfo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import apfo_pkg::*;

    t_coefs   r_coefs;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    t_ff_item q_in;
    t_ff_item q_out;

    assign o_cfg_ready = 1'b1;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RESET;
            r_coefs.b1 <= B1_RESET;
            r_coefs.a1 <= A1_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_B0:  r_coefs.b0 <= i_cfg_data;
                CFG_B1:  r_coefs.b1 <= i_cfg_data;
                CFG_A1:  r_coefs.a1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    apfo_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coefs  (r_coefs),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata),
        .i_clear  (s_axis_tuser[0]),
        .o_push   (q_push),
        .o_item   (q_in),
        .i_full   (q_full)
    );

    apfo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    apfo_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_a1     (r_coefs.a1),
        .i_empty  (q_empty),
        .i_item   (q_out),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_sample (m_axis_tdata),
        .o_sat    (m_axis_tuser[0])
    );

endmodule

// ===== rtl/apfo_checker.sv =====
// Port-level checks of the all-pass filter, bound to the top level.
// Depends on allpass_first_order_q30_defines.svh and allpass_first_order_q30.
`include "allpass_first_order_q30_defines.svh"

module apfo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic        out_stall;
    logic [32:0] out_beat;
    logic        out_on_rail;

    // Output beat as seen on the master side
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_beat    = {m_axis_tuser, m_axis_tdata};
    assign out_on_rail = (m_axis_tdata == 32'h7fff_ffff) || (m_axis_tdata == 32'h8000_0000);

    // Output stream is empty right after reset
    `APFO_ASSERT_RST(a_out_idle_after_rst, !i_rst_n |=> !m_axis_tvalid)

    // Input side is open right after reset
    `APFO_ASSERT_RST(a_in_ready_after_rst, !i_rst_n |=> s_axis_tready)

    // Hold a stalled output beat
    `APFO_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat))

    // A clamped sample sits on a rail
    `APFO_ASSERT(a_sat_rail, m_axis_tvalid && m_axis_tuser[0] |-> out_on_rail)

endmodule

bind allpass_first_order_q30 apfo_checker u_apfo_checker (.*);
